// ===== rtl/cascaded_interrupt_controller_top_defines.svh =====
// assertion macros used by the checker
`ifndef CASCADED_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define CASCADED_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define CIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cic assertion failed");

// next-cycle implication
`define CIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cic assertion failed");

`endif

// ===== rtl/cic_pkg.sv =====
package cic_pkg;

	localparam logic [2:0] KIND_PORT_WR = 3'd0;
	localparam logic [2:0] KIND_PORT_RD = 3'd1;
	localparam logic [2:0] KIND_ELCR_WR = 3'd2;
	localparam logic [2:0] KIND_ELCR_RD = 3'd3;
	localparam logic [2:0] KIND_RAISE   = 3'd4;
	localparam logic [2:0] KIND_LOWER   = 3'd5;
	localparam logic [2:0] KIND_ACK     = 3'd6;

	localparam logic [1:0] CMD_SEL_OCW2 = 2'd0;
	localparam logic [1:0] CMD_SEL_OCW3 = 2'd1;

	localparam logic [7:0] OCW2_ROTATE   = 8'h80;
	localparam logic [7:0] OCW2_SPECIFIC = 8'h40;
	localparam logic [7:0] OCW2_EOI      = 8'h20;
	localparam logic [7:0] OCW3_UNSUP    = 8'h44;
	localparam logic [7:0] BASE_MASK     = 8'hF8;
	localparam logic [2:0] LINE_SPURIOUS = 3'd7;
	localparam logic [2:0] LINE_CASCADE  = 3'd2;
	localparam logic [2:0] PRIO_RESET    = 3'd7;

	localparam logic [2:0] STEP_ICW2 = 3'd2;
	localparam logic [2:0] STEP_ICW3 = 3'd3;
	localparam logic [2:0] STEP_ICW4 = 3'd4;
	localparam logic [2:0] STEP_DONE = 3'd5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_OCW2,
		OP_OCW3,
		OP_ICW1,
		OP_DATA_WR,
		OP_READ_MASK,
		OP_READ_CMD,
		OP_ELCR_WR,
		OP_ELCR_RD,
		OP_RAISE,
		OP_LOWER,
		OP_ACK
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       chip;
		logic [7:0] data;
		logic [2:0] line;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] line;
	} scan_t;

	// rotating priority scan, stopped by an in-service line
	function automatic scan_t prio_resolve(input logic [7:0] req, input logic [7:0] mask,
			input logic [7:0] isr, input logic [2:0] base);
		scan_t      r;
		logic       stop;
		logic [7:0] live;
		logic [2:0] ln;
		int         i;
		r    = '0;
		stop = 1'b0;
		live = req & ~mask;
		for (i = 0; i < 8; i++) begin
			ln = base + 3'd1 + 3'(i);
			if (!stop) begin
				if (isr[ln]) begin
					stop = 1'b1;
				end else if (live[ln]) begin
					r.hit  = 1'b1;
					r.line = ln;
					stop   = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// highest priority in-service line for non-specific eoi
	function automatic scan_t isr_first(input logic [7:0] isr, input logic [2:0] base);
		scan_t      r;
		logic [2:0] ln;
		int         i;
		r = '0;
		for (i = 0; i < 8; i++) begin
			ln = base + 3'd1 + 3'(i);
			if (!r.hit && isr[ln]) begin
				r.hit  = 1'b1;
				r.line = ln;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/cic_front.sv =====
module cic_front (
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [2:0]          kind,
	input  logic                chip,
	input  logic                port_a0,
	input  logic [7:0]          write_data,
	input  logic [2:0]          irq_line,
	input  logic                q_full,
	output logic                q_push,
	output cic_pkg::entry_t     q_entry
);

	cic_pkg::op_t op;

	always_comb begin
		op = cic_pkg::OP_NOP;
		case (kind)
			cic_pkg::KIND_PORT_WR: begin
				if (port_a0) begin
					op = cic_pkg::OP_DATA_WR;
				end else if (write_data[4:3] == cic_pkg::CMD_SEL_OCW2) begin
					op = cic_pkg::OP_OCW2;
				end else if (write_data[4:3] == cic_pkg::CMD_SEL_OCW3) begin
					op = cic_pkg::OP_OCW3;
				end else begin
					op = cic_pkg::OP_ICW1;
				end
			end
			cic_pkg::KIND_PORT_RD: begin
				op = port_a0 ? cic_pkg::OP_READ_MASK : cic_pkg::OP_READ_CMD;
			end
			cic_pkg::KIND_ELCR_WR: op = cic_pkg::OP_ELCR_WR;
			cic_pkg::KIND_ELCR_RD: op = cic_pkg::OP_ELCR_RD;
			cic_pkg::KIND_RAISE:   op = cic_pkg::OP_RAISE;
			cic_pkg::KIND_LOWER:   op = cic_pkg::OP_LOWER;
			cic_pkg::KIND_ACK:     op = cic_pkg::OP_ACK;
			default:               op = cic_pkg::OP_NOP;
		endcase
	end

	assign item_stall    = q_full;
	assign q_push        = item_valid && !q_full;
	assign q_entry.op    = op;
	assign q_entry.chip  = chip;
	assign q_entry.data  = write_data;
	assign q_entry.line  = irq_line;

endmodule

// ===== rtl/cic_queue.sv =====
module cic_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cic_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output cic_pkg::entry_t pop_entry
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cic_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/cic_back.sv =====
module cic_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  cic_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [7:0]      read_data,
	output logic [7:0]      vector,
	output logic            cpu_int,
	output logic            status
);

	logic [7:0] mask_q [2];
	logic [7:0] req_q  [2];
	logic [7:0] isr_q  [2];
	logic [7:0] elcr_q [2];
	logic [7:0] pin_q  [2];
	logic [7:0] vb_q   [2];
	logic [2:0] lpl_q  [2];
	logic [2:0] pend_q [2];
	logic [2:0] step_q [2];
	logic [1:0] iact_q;
	logic [1:0] ris_q;
	logic       cpu_q;

	logic [7:0] mask_d [2];
	logic [7:0] req_d  [2];
	logic [7:0] isr_d  [2];
	logic [7:0] elcr_d [2];
	logic [7:0] pin_d  [2];
	logic [7:0] vb_d   [2];
	logic [2:0] lpl_d  [2];
	logic [2:0] pend_d [2];
	logic [2:0] step_d [2];
	logic [1:0] iact_d;
	logic [1:0] ris_d;
	logic       cpu_d;

	logic [7:0]      rd_d;
	logic [7:0]      vec_d;
	logic            st_d;
	logic            res_en;
	logic            mres_en;
	logic            c;
	logic [7:0]      d;
	logic [2:0]      ln;
	logic [2:0]      ln0;
	logic [2:0]      ln1;
	cic_pkg::scan_t  eoi;
	cic_pkg::scan_t  r1;
	cic_pkg::scan_t  r0;
	logic            result_valid_q;
	logic [7:0]      read_data_q;
	logic [7:0]      vector_q;
	logic            cpu_int_q;
	logic            status_q;

	assign q_pop = q_valid && (!result_valid_q || !result_stall);

	always_comb begin
		mask_d = mask_q;
		req_d  = req_q;
		isr_d  = isr_q;
		elcr_d = elcr_q;
		pin_d  = pin_q;
		vb_d   = vb_q;
		lpl_d  = lpl_q;
		pend_d = pend_q;
		step_d = step_q;
		iact_d = iact_q;
		ris_d  = ris_q;
		cpu_d  = cpu_q;
		rd_d    = '0;
		vec_d   = '0;
		st_d    = 1'b0;
		res_en  = 1'b0;
		mres_en = 1'b0;
		c   = q_entry.chip;
		d   = q_entry.data;
		ln  = q_entry.line;
		ln0 = pend_q[0];
		ln1 = pend_q[1];
		eoi = cic_pkg::isr_first(isr_q[c], lpl_q[c]);
		r1  = '0;
		r0  = '0;
		case (q_entry.op)
			cic_pkg::OP_OCW2: begin
				if ((d & cic_pkg::OCW2_EOI) != '0) begin
					if ((d & cic_pkg::OCW2_SPECIFIC) != '0) begin
						isr_d[c][d[2:0]] = 1'b0;
						if ((d & cic_pkg::OCW2_ROTATE) != '0) begin
							lpl_d[c] = d[2:0];
						end
					end else if (eoi.hit) begin
						isr_d[c][eoi.line] = 1'b0;
						if ((d & cic_pkg::OCW2_ROTATE) != '0) begin
							lpl_d[c] = eoi.line;
						end
					end
					res_en = 1'b1;
				end else if ((d & cic_pkg::OCW2_SPECIFIC) == '0) begin
					st_d = 1'b1;
				end else if ((d & cic_pkg::OCW2_ROTATE) != '0) begin
					lpl_d[c] = d[2:0];
				end
			end
			cic_pkg::OP_OCW3: begin
				if (d[1]) begin
					ris_d[c] = d[0];
				end else if ((d & cic_pkg::OCW3_UNSUP) != '0) begin
					st_d = 1'b1;
				end
			end
			cic_pkg::OP_ICW1: begin
				if (!d[0] || d[1]) begin
					st_d = 1'b1;
				end else begin
					cpu_d     = 1'b0;
					iact_d[c] = 1'b1;
					mask_d[c] = '0;
					isr_d[c]  = '0;
					req_d[c]  = '0;
					lpl_d[c]  = cic_pkg::PRIO_RESET;
					step_d[c] = cic_pkg::STEP_ICW2;
				end
			end
			cic_pkg::OP_DATA_WR: begin
				if (!iact_q[c]) begin
					mask_d[c] = d;
					res_en    = 1'b1;
				end else begin
					case (step_q[c])
						cic_pkg::STEP_ICW2: begin
							vb_d[c]   = d & cic_pkg::BASE_MASK;
							step_d[c] = cic_pkg::STEP_ICW3;
						end
						cic_pkg::STEP_ICW3: begin
							step_d[c] = cic_pkg::STEP_ICW4;
						end
						cic_pkg::STEP_ICW4: begin
							if (!d[0] || d[1] || d[3] || d[4]) begin
								st_d = 1'b1;
							end else begin
								iact_d[c] = 1'b0;
								step_d[c] = cic_pkg::STEP_DONE;
							end
						end
						default: st_d = 1'b1;
					endcase
				end
			end
			cic_pkg::OP_READ_MASK: rd_d = mask_q[c];
			cic_pkg::OP_READ_CMD:  rd_d = ris_q[c] ? isr_q[c] : req_q[c];
			cic_pkg::OP_ELCR_WR:   elcr_d[c] = d;
			cic_pkg::OP_ELCR_RD:   rd_d = elcr_q[c];
			cic_pkg::OP_RAISE: begin
				if (elcr_q[c][ln] || !pin_q[c][ln]) begin
					pin_d[c][ln] = 1'b1;
					req_d[c][ln] = 1'b1;
					res_en       = 1'b1;
				end
			end
			cic_pkg::OP_LOWER: begin
				pin_d[c][ln] = 1'b0;
				req_d[c][ln] = 1'b0;
				if (c && (req_d[1] == '0)) begin
					pin_d[0][cic_pkg::LINE_CASCADE] = 1'b0;
					req_d[0][cic_pkg::LINE_CASCADE] = 1'b0;
				end
			end
			cic_pkg::OP_ACK: begin
				cpu_d = 1'b0;
				if (!req_q[0][ln0]) begin
					vec_d = vb_q[0] | {5'd0, cic_pkg::LINE_SPURIOUS};
				end else begin
					if (!elcr_q[0][ln0]) begin
						req_d[0][ln0] = 1'b0;
					end
					isr_d[0][ln0] = 1'b1;
					if (ln0 == cic_pkg::LINE_CASCADE) begin
						if (!req_q[1][ln1]) begin
							vec_d = vb_q[1] | {5'd0, cic_pkg::LINE_SPURIOUS};
						end else begin
							if (!elcr_q[1][ln1]) begin
								req_d[1][ln1] = 1'b0;
							end
							isr_d[1][ln1] = 1'b1;
							vec_d = vb_q[1] + {5'd0, ln1};
						end
					end else begin
						vec_d = vb_q[0] + {5'd0, ln0};
					end
				end
			end
			default: begin
			end
		endcase

		// slave resolution cascades into the master
		if (res_en && c) begin
			r1 = cic_pkg::prio_resolve(req_d[1], mask_d[1], isr_d[1], lpl_d[1]);
			if (r1.hit) begin
				pend_d[1] = r1.line;
				pin_d[0][cic_pkg::LINE_CASCADE] = 1'b1;
				req_d[0][cic_pkg::LINE_CASCADE] = 1'b1;
				mres_en = 1'b1;
			end
		end
		if (res_en && !c) begin
			mres_en = 1'b1;
		end
		if (mres_en) begin
			r0 = cic_pkg::prio_resolve(req_d[0], mask_d[0], isr_d[0], lpl_d[0]);
			if (r0.hit) begin
				pend_d[0] = r0.line;
				cpu_d     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				mask_q[i] <= 8'hFF;
				req_q[i]  <= '0;
				isr_q[i]  <= '0;
				elcr_q[i] <= '0;
				pin_q[i]  <= '0;
				vb_q[i]   <= '0;
				lpl_q[i]  <= cic_pkg::PRIO_RESET;
				pend_q[i] <= '0;
				step_q[i] <= '0;
			end
			iact_q         <= '0;
			ris_q          <= '0;
			cpu_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mask_q <= mask_d;
				req_q  <= req_d;
				isr_q  <= isr_d;
				elcr_q <= elcr_d;
				pin_q  <= pin_d;
				vb_q   <= vb_d;
				lpl_q  <= lpl_d;
				pend_q <= pend_d;
				step_q <= step_d;
				iact_q <= iact_d;
				ris_q  <= ris_d;
				cpu_q  <= cpu_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			read_data_q <= rd_d;
			vector_q    <= vec_d;
			cpu_int_q   <= cpu_d;
			status_q    <= st_d;
		end
	end

	assign result_valid = result_valid_q;
	assign read_data    = read_data_q;
	assign vector       = vector_q;
	assign cpu_int      = cpu_int_q;
	assign status       = status_q;

endmodule

// ===== rtl/cascaded_interrupt_controller_top.sv =====
// path: an accepted beat is written into the queue, then executed by the back end into the output register
// throughput: one beat per cycle unless a held result is stalled, set by the execute stage in the back end
// the two-entry queue lets the front keep taking beats while a result waits
// reset: asynchronous, resets queue, output valid and all controller state
// masks reset to all ones, rotation base to seven, no clearing pass
module cascaded_interrupt_controller_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] kind,
	input  logic       chip,
	input  logic       port_a0,
	input  logic [7:0] write_data,
	input  logic [2:0] irq_line,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] read_data,
	output logic [7:0] vector,
	output logic       cpu_int,
	output logic       status
);

	cic_pkg::entry_t push_entry;
	cic_pkg::entry_t pop_entry;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_not_empty;

	cic_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.chip       (chip),
		.port_a0    (port_a0),
		.write_data (write_data),
		.irq_line   (irq_line),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	cic_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	cic_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_entry      (pop_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.vector       (vector),
		.cpu_int      (cpu_int),
		.status       (status)
	);

endmodule

// ===== rtl/cic_checker.sv =====
`include "cascaded_interrupt_controller_top_defines.svh"

module cic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] read_data,
	input logic [7:0] vector,
	input logic       cpu_int,
	input logic       status
);

	`CIC_ASSERT_NEXT(a_valid_hold, clk, arst_n, result_valid && result_stall, result_valid)
	`CIC_ASSERT_NEXT(a_beat_hold, clk, arst_n, result_valid && result_stall, $stable(read_data) && $stable(vector) && $stable(cpu_int) && $stable(status))
	`CIC_ASSERT_IMPL(a_err_quiet, clk, arst_n, result_valid && status, (read_data == 8'd0) && (vector == 8'd0))
	`CIC_ASSERT_IMPL(a_vec_alone, clk, arst_n, result_valid && (vector != 8'd0), (read_data == 8'd0) && !status)

endmodule

bind cascaded_interrupt_controller_top cic_checker u_cic_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] rd;
	logic [7:0] vec;
	logic       irq;
	logic       st;
} pic_reply_t;

class pic_pair_scoreboard;
	bit [7:0]   imr [2];
	bit [7:0]   irr [2];
	bit [7:0]   isr [2];
	bit [7:0]   elcr [2];
	bit [7:0]   pins [2];
	bit [7:0]   vbase [2];
	bit [2:0]   low_prio [2];
	bit [2:0]   pend [2];
	bit [2:0]   istep [2];
	bit         init_busy [2];
	bit         rd_isr [2];
	bit         intr;
	pic_reply_t replies[$];
	int         errors;
	int         n_beats;
	int         n_acks;
	int         n_spurious;
	int         n_unsup;
	int         n_irq;

	function new();
		int c;
		for (c = 0; c < 2; c++) begin
			imr[c]       = 8'hFF;
			irr[c]       = '0;
			isr[c]       = '0;
			elcr[c]      = '0;
			pins[c]      = '0;
			vbase[c]     = '0;
			low_prio[c]  = cic_pkg::PRIO_RESET;
			pend[c]      = '0;
			istep[c]     = '0;
			init_busy[c] = 1'b0;
			rd_isr[c]    = 1'b0;
		end
		intr = 1'b0;
	endfunction

	// rotating scan, an in-service line blocks everything below it
	function void resolve(int c);
		bit [7:0] live;
		bit [2:0] ln;
		int       i;
		live = irr[c] & ~imr[c];
		if (live == 0)
			return;
		for (i = 0; i < 8; i++) begin
			ln = low_prio[c] + 3'd1 + i[2:0];
			if (isr[c][ln])
				return;
			if (live[ln]) begin
				pend[c] = ln;
				if (c == 0) begin
					intr = 1'b1;
				end else begin
					pins[0][cic_pkg::LINE_CASCADE] = 1'b1;
					irr[0][cic_pkg::LINE_CASCADE]  = 1'b1;
					resolve(0);
				end
				return;
			end
		end
	endfunction

	function bit [7:0] ack_vector(int c);
		bit [2:0] ln;
		ln = pend[c];
		if (!irr[c][ln]) begin
			n_spurious++;
			return vbase[c] | {5'd0, cic_pkg::LINE_SPURIOUS};
		end
		if (!elcr[c][ln])
			irr[c][ln] = 1'b0;
		isr[c][ln] = 1'b1;
		if (c == 0 && ln == cic_pkg::LINE_CASCADE)
			return ack_vector(1);
		return vbase[c] + {5'd0, ln};
	endfunction

	function bit ocw2_write(int c, bit [7:0] v);
		bit [2:0] lvl;
		bit [2:0] ln;
		bit       rot;
		bit       spec;
		int       i;
		lvl  = v[2:0];
		rot  = (v & cic_pkg::OCW2_ROTATE) != 0;
		spec = (v & cic_pkg::OCW2_SPECIFIC) != 0;
		if ((v & cic_pkg::OCW2_EOI) != 0) begin
			if (spec) begin
				isr[c][lvl] = 1'b0;
				if (rot)
					low_prio[c] = lvl;
			end else begin
				for (i = 0; i < 8; i++) begin
					ln = low_prio[c] + 3'd1 + i[2:0];
					if (isr[c][ln]) begin
						isr[c][ln] = 1'b0;
						if (rot)
							low_prio[c] = ln;
						break;
					end
				end
			end
			resolve(c);
			return 1'b0;
		end
		if (!spec)
			return 1'b1;
		if (rot)
			low_prio[c] = lvl;
		return 1'b0;
	endfunction

	function bit port_write(int c, bit a0, bit [7:0] v);
		if (!a0) begin
			if (v[4:3] == cic_pkg::CMD_SEL_OCW2)
				return ocw2_write(c, v);
			if (v[4:3] == cic_pkg::CMD_SEL_OCW3) begin
				if (v[1])
					rd_isr[c] = v[0];
				else if ((v & cic_pkg::OCW3_UNSUP) != 0)
					return 1'b1;
				return 1'b0;
			end
			if (!v[0] || v[1])
				return 1'b1;
			intr         = 1'b0;
			init_busy[c] = 1'b1;
			imr[c]       = '0;
			isr[c]       = '0;
			irr[c]       = '0;
			low_prio[c]  = cic_pkg::PRIO_RESET;
			istep[c]     = cic_pkg::STEP_ICW2;
			return 1'b0;
		end
		if (!init_busy[c]) begin
			imr[c] = v;
			resolve(c);
			return 1'b0;
		end
		case (istep[c])
			cic_pkg::STEP_ICW2: begin
				vbase[c] = v & cic_pkg::BASE_MASK;
				istep[c] = cic_pkg::STEP_ICW3;
				return 1'b0;
			end
			cic_pkg::STEP_ICW3: begin
				istep[c] = cic_pkg::STEP_ICW4;
				return 1'b0;
			end
			cic_pkg::STEP_ICW4: begin
				if (!v[0] || v[1] || v[3] || v[4])
					return 1'b1;
				init_busy[c] = 1'b0;
				istep[c]     = cic_pkg::STEP_DONE;
				return 1'b0;
			end
			default: return 1'b1;
		endcase
	endfunction

	function void predict_access(bit [2:0] k, bit c, bit a0, bit [7:0] v, bit [2:0] ln);
		pic_reply_t r;
		bit [7:0]   b;
		r = '0;
		b = 8'd1 << ln;
		case (k)
			cic_pkg::KIND_PORT_WR: r.st = port_write(c, a0, v);
			cic_pkg::KIND_PORT_RD:
				r.rd = a0 ? imr[c] : (rd_isr[c] ? isr[c] : irr[c]);
			cic_pkg::KIND_ELCR_WR: elcr[c] = v;
			cic_pkg::KIND_ELCR_RD: r.rd = elcr[c];
			cic_pkg::KIND_RAISE: begin
				if ((elcr[c] & b) != 0 || (pins[c] & b) == 0) begin
					pins[c] |= b;
					irr[c]  |= b;
					resolve(c);
				end
			end
			cic_pkg::KIND_LOWER: begin
				pins[c] &= ~b;
				irr[c]  &= ~b;
				if (c && irr[1] == 0) begin
					pins[0][cic_pkg::LINE_CASCADE] = 1'b0;
					irr[0][cic_pkg::LINE_CASCADE]  = 1'b0;
				end
			end
			cic_pkg::KIND_ACK: begin
				intr  = 1'b0;
				r.vec = ack_vector(0);
				n_acks++;
			end
			default: ;
		endcase
		r.irq = intr;
		n_beats++;
		if (r.st)
			n_unsup++;
		if (r.irq)
			n_irq++;
		replies.push_back(r);
	endfunction

	function void check_reply(logic [7:0] rd, logic [7:0] vec, logic irq, logic st);
		pic_reply_t e;
		if (replies.size() == 0) begin
			$error("result beat with no expectation pending");
			errors++;
			return;
		end
		e = replies.pop_front();
		if (rd !== e.rd) begin
			$error("read_data mismatch: expected %02h, actual %02h", e.rd, rd);
			errors++;
		end
		if (vec !== e.vec) begin
			$error("vector mismatch: expected %02h, actual %02h", e.vec, vec);
			errors++;
		end
		if (irq !== e.irq) begin
			$error("cpu_int mismatch: expected %0b, actual %0b", e.irq, irq);
			errors++;
		end
		if (st !== e.st) begin
			$error("status mismatch: expected %0b, actual %0b", e.st, st);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int         N_BEATS     = 1800;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	logic [2:0] kind         = '0;
	logic       chip         = 1'b0;
	logic       port_a0      = 1'b0;
	logic [7:0] write_data   = '0;
	logic [2:0] irq_line     = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] read_data;
	logic [7:0] vector;
	logic       cpu_int;
	logic       status;

	int tx_idle_pct = 14;
	int rx_stall_pct = 71;

	pic_pair_scoreboard board = new();

	cascaded_interrupt_controller_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.chip         (chip),
		.port_a0      (port_a0),
		.write_data   (write_data),
		.irq_line     (irq_line),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.vector       (vector),
		.cpu_int      (cpu_int),
		.status       (status)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0)
			board.check_reply(read_data, vector, cpu_int, status);
		result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	task automatic send_beat(bit [2:0] k, bit c, bit a0, bit [7:0] v, bit [2:0] ln);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		chip       <= c;
		port_a0    <= a0;
		write_data <= v;
		irq_line   <= ln;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		board.predict_access(k, c, a0, v, ln);
	endtask

	// well-formed init word sequence with random don't-care bits
	task automatic init_chip(bit c, bit [7:0] base);
		send_beat(cic_pkg::KIND_PORT_WR, c, 1'b0,
			{3'($urandom), 1'b1, 2'($urandom), 1'b0, 1'b1}, 3'($urandom));
		send_beat(cic_pkg::KIND_PORT_WR, c, 1'b1, base, 3'($urandom));
		send_beat(cic_pkg::KIND_PORT_WR, c, 1'b1, 8'($urandom), 3'($urandom));
		send_beat(cic_pkg::KIND_PORT_WR, c, 1'b1,
			{3'($urandom), 2'b00, 1'($urandom), 1'b0, 1'b1}, 3'($urandom));
	endtask

	initial begin
		int       r;
		int       wait_cycles;
		bit       c;
		bit [2:0] ln;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_beat(cic_pkg::KIND_ACK, 1'b1, 1'b0, 8'h00, 3'd0);
		send_beat(cic_pkg::KIND_PORT_RD, 1'b0, 1'b1, 8'h00, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h10, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h12, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h80, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h0C, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h11, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b1, 8'h20, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b1, 8'h04, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b1, 8'h1F, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b1, 8'h01, 3'd0);
		init_chip(1'b1, 8'hA8);
		send_beat(cic_pkg::KIND_RAISE, 1'b1, 1'b0, 8'h00, 3'd7);
		send_beat(cic_pkg::KIND_ACK, 1'b0, 1'b0, 8'h00, 3'd0);
		send_beat(cic_pkg::KIND_RAISE, 1'b0, 1'b0, 8'h00, 3'd1);
		send_beat(cic_pkg::KIND_ACK, 1'b1, 1'b1, 8'hFF, 3'd7);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'h0B, 3'd0);
		send_beat(cic_pkg::KIND_PORT_RD, 1'b0, 1'b0, 8'h00, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'hA0, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b1, 1'b0, 8'h67, 3'd0);
		send_beat(cic_pkg::KIND_PORT_WR, 1'b0, 1'b0, 8'hC3, 3'd0);
		send_beat(cic_pkg::KIND_ELCR_WR, 1'b1, 1'b0, 8'hFF, 3'd0);
		send_beat(cic_pkg::KIND_RAISE, 1'b1, 1'b0, 8'h00, 3'd7);
		send_beat(cic_pkg::KIND_ELCR_RD, 1'b1, 1'b0, 8'h00, 3'd0);
		send_beat(cic_pkg::KIND_LOWER, 1'b1, 1'b0, 8'h00, 3'd7);
		send_beat(KIND_UNUSED, 1'b1, 1'b1, 8'hFF, 3'd7);

		// random traffic, mostly well-formed controller usage
		while (board.n_beats < N_BEATS) begin
			if (board.n_beats >= 2 * N_BEATS / 3) begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end else if (board.n_beats >= N_BEATS / 3) begin
				tx_idle_pct  = 71;
				rx_stall_pct = 14;
			end
			r  = $urandom_range(0, 99);
			c  = 1'($urandom);
			ln = 3'($urandom);
			if (r < 3)
				init_chip(c, 8'($urandom));
			else if (r < 28)
				send_beat(cic_pkg::KIND_RAISE, c, 1'($urandom), 8'($urandom), ln);
			else if (r < 40)
				send_beat(cic_pkg::KIND_LOWER, c, 1'($urandom), 8'($urandom), ln);
			else if (r < 55)
				send_beat(cic_pkg::KIND_ACK, c, 1'($urandom), 8'($urandom), ln);
			else if (r < 67)
				send_beat(cic_pkg::KIND_PORT_WR, c, 1'b0,
					{1'($urandom), 1'($urandom), 1'b1, 2'b00, 3'($urandom)}, ln);
			else if (r < 70)
				send_beat(cic_pkg::KIND_PORT_WR, c, 1'b0,
					{1'($urandom), 1'($urandom), 1'b0, 2'b00, 3'($urandom)}, ln);
			else if (r < 74)
				send_beat(cic_pkg::KIND_PORT_WR, c, 1'b0,
					{1'($urandom), 1'($urandom), 1'b0, 2'b01, 3'($urandom)}, ln);
			else if (r < 80)
				send_beat(cic_pkg::KIND_PORT_WR, c, 1'b1,
					8'($urandom & $urandom & $urandom), ln);
			else if (r < 86)
				send_beat(cic_pkg::KIND_PORT_RD, c, 1'($urandom), 8'($urandom), ln);
			else if (r < 89)
				send_beat(cic_pkg::KIND_ELCR_WR, c, 1'($urandom),
					8'($urandom & $urandom), ln);
			else if (r < 91)
				send_beat(cic_pkg::KIND_ELCR_RD, c, 1'($urandom), 8'($urandom), ln);
			else
				send_beat(3'($urandom), c, 1'($urandom), 8'($urandom), ln);
		end
		item_valid <= 1'b0;

		wait_cycles = 0;
		while (board.replies.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (board.replies.size() != 0) begin
			$error("%0d expected results never arrived", board.replies.size());
			board.errors++;
		end

		$display("run: %0d beats over three handshake pressure phases, %0d acknowledges",
			board.n_beats, board.n_acks);
		$display("run: %0d spurious vectors, %0d unsupported commands, %0d with cpu_int high",
			board.n_spurious, board.n_unsup, board.n_irq);
		if (board.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end
endmodule
